// ===== hdl/fdfp_pkg.sv =====
package fdfp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CmdW    = 4;
  localparam int unsigned AmountW = 32;
  localparam int unsigned FracW   = 7;
  localparam int unsigned CountW  = 16;
  localparam int unsigned CfgIdxW = 1;

  localparam int unsigned SUM_QUEUE_DEPTH = 2;

  localparam logic [ByteW-1:0] OPEN_MARK  = 8'h7B;
  localparam logic [ByteW-1:0] CLOSE_MARK = 8'h7D;
  localparam logic [ByteW-1:0] ASCII_ZERO = 8'h30;
  localparam logic [ByteW-1:0] ASCII_ONE  = 8'h31;
  localparam logic [ByteW-1:0] ASCII_NINE = 8'h39;
  localparam logic [ByteW-1:0] ASCII_DOT  = 8'h2E;

  localparam logic [ByteW-1:0] MAX_LINE_RESET   = 8'd18;
  localparam logic [ByteW-1:0] MAX_SCREEN_RESET = 8'd86;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_MAX_LINE   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_MAX_SCREEN = 1'd1;

  // Command codes.
  localparam logic [CmdW-1:0] CMD_NONE    = 4'd0;
  localparam logic [CmdW-1:0] CMD_1       = 4'd1;
  localparam logic [CmdW-1:0] CMD_2       = 4'd2;
  localparam logic [CmdW-1:0] CMD_LINE    = 4'd3;
  localparam logic [CmdW-1:0] CMD_SCREEN  = 4'd4;
  localparam logic [CmdW-1:0] CMD_5       = 4'd5;
  localparam logic [CmdW-1:0] CMD_ROW_CLR = 4'd6;
  localparam logic [CmdW-1:0] CMD_VOICE   = 4'd7;
  localparam logic [CmdW-1:0] CMD_BRIGHT  = 4'd8;
  localparam logic [CmdW-1:0] CMD_VOLUME  = 4'd9;
  localparam logic [CmdW-1:0] CMD_PERIPH  = 4'd10;
  localparam logic [CmdW-1:0] CMD_FEE     = 4'd11;
  localparam logic [CmdW-1:0] CMD_FILL    = 4'd12;
  localparam logic [CmdW-1:0] CMD_VERSION = 4'd13;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FRAME_ERR = 2'd1,
    ST_CMD_ERR   = 2'd2,
    ST_PARAM_ERR = 2'd3
  } status_e;

  // Everything the back end needs to know about one finished frame.
  typedef struct packed {
    logic              frame_bad;
    logic              len_short;
    logic [CmdW-1:0]   cmd;
    logic [ByteW-1:0]  dl;
    logic [ByteW-1:0]  d0;
    logic [ByteW-1:0]  d1;
    logic [ByteW-1:0]  d2;
    logic [AmountW-1:0] int_accum;
    logic [FracW-1:0]  frac;
  } frame_sum_t;

  typedef struct packed {
    status_e            status;
    logic [CmdW-1:0]    command;
    logic [ByteW-1:0]   param_len;
    logic [ByteW-1:0]   colour;
    logic [ByteW-1:0]   row;
    logic [ByteW-1:0]   x_pos;
    logic [ByteW-1:0]   y_pos;
    logic [ByteW-1:0]   text_bytes;
    logic [ByteW-1:0]   level_value;
    logic [AmountW-1:0] fee_amount;
  } result_t;

endpackage

// ===== hdl/fdfp_front.sv =====
module fdfp_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     accept_i,
  input  logic [fdfp_pkg::ByteW-1:0] frame_byte_i,
  input  logic                     last_byte_i,
  output logic                     sum_push_o,
  output fdfp_pkg::frame_sum_t     sum_o
);
  import fdfp_pkg::*;

  typedef enum logic [1:0] {
    PH_INT,
    PH_FRAC1,
    PH_FRAC2,
    PH_DONE
  } phase_e;

  logic [CountW-1:0]  byte_count_q, byte_count_d;
  logic               open_ok_q, open_ok_d;
  logic [CmdW-1:0]    cmd_q, cmd_d;
  logic [ByteW-1:0]   dl_q, dl_d;
  logic [ByteW-1:0]   head_q [3];
  logic [ByteW-1:0]   head_d [3];
  logic [AmountW-1:0] int_q, int_d;
  logic [FracW-1:0]   frac_q, frac_d;
  phase_e             phase_q, phase_d;

  logic [CountW-1:0]  param_idx;
  logic               is_digit;
  logic [3:0]         digit;
  logic               len_short;

  function automatic logic [CmdW-1:0] decode_cmd(input logic [ByteW-1:0] b);
    logic [CmdW-1:0] c;
    c = CMD_NONE;
    if (b >= ASCII_ONE && b <= ASCII_NINE) begin
      c = CmdW'(b - ASCII_ZERO);
    end else if (b == 8'h41) begin
      c = CMD_PERIPH;
    end else if (b == 8'h42) begin
      c = CMD_FEE;
    end else if (b == 8'h01) begin
      c = CMD_FILL;
    end else if (b == 8'h02) begin
      c = CMD_VERSION;
    end
    return c;
  endfunction

  assign param_idx = byte_count_q - CountW'(3);
  assign is_digit  = (frame_byte_i >= ASCII_ZERO) && (frame_byte_i <= ASCII_NINE);
  assign digit     = 4'(frame_byte_i - ASCII_ZERO);

  always_comb begin
    byte_count_d = byte_count_q;
    open_ok_d    = open_ok_q;
    cmd_d        = cmd_q;
    dl_d         = dl_q;
    head_d       = head_q;
    int_d        = int_q;
    frac_d       = frac_q;
    phase_d      = phase_q;

    if (byte_count_q == CountW'(0)) begin
      open_ok_d = (frame_byte_i == OPEN_MARK);
    end else if (byte_count_q == CountW'(1)) begin
      cmd_d = decode_cmd(frame_byte_i);
    end else if (byte_count_q == CountW'(2)) begin
      dl_d = frame_byte_i;
    end else if (param_idx < {8'h00, dl_q}) begin
      if (param_idx < CountW'(3)) begin
        head_d[param_idx[1:0]] = frame_byte_i;
      end
      case (phase_q)
        PH_INT: begin
          if (is_digit) begin
            int_d = (int_q << 3) + (int_q << 1) + {28'd0, digit};
          end else if (frame_byte_i == ASCII_DOT) begin
            phase_d = PH_FRAC1;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_FRAC1: begin
          if (is_digit) begin
            frac_d  = FracW'(digit) * FracW'(10);
            phase_d = PH_FRAC2;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_FRAC2: begin
          if (is_digit) begin
            frac_d = frac_q + {3'd0, digit};
          end
          phase_d = PH_DONE;
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end

    if (byte_count_q != {CountW{1'b1}}) begin
      byte_count_d = byte_count_q + CountW'(1);
    end
  end

  // Declared length exceeds what arrived: total - 4 < L, total = count + 1.
  assign len_short = (byte_count_q >= CountW'(3)) && (param_idx < {8'h00, dl_d});

  always_comb begin
    sum_o.frame_bad = (byte_count_q < CountW'(3)) || !open_ok_d ||
                      (frame_byte_i != CLOSE_MARK);
    sum_o.len_short = len_short;
    sum_o.cmd       = cmd_d;
    sum_o.dl        = dl_d;
    sum_o.d0        = head_d[0];
    sum_o.d1        = head_d[1];
    sum_o.d2        = head_d[2];
    sum_o.int_accum = int_d;
    sum_o.frac      = frac_d;
  end

  assign sum_push_o = accept_i && last_byte_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q <= '0;
      open_ok_q    <= 1'b0;
      cmd_q        <= CMD_NONE;
      dl_q         <= '0;
      head_q       <= '{default: '0};
      int_q        <= '0;
      frac_q       <= '0;
      phase_q      <= PH_INT;
    end else if (accept_i) begin
      if (last_byte_i) begin
        byte_count_q <= '0;
        open_ok_q    <= 1'b0;
        cmd_q        <= CMD_NONE;
        dl_q         <= '0;
        head_q       <= '{default: '0};
        int_q        <= '0;
        frac_q       <= '0;
        phase_q      <= PH_INT;
      end else begin
        byte_count_q <= byte_count_d;
        open_ok_q    <= open_ok_d;
        cmd_q        <= cmd_d;
        dl_q         <= dl_d;
        head_q       <= head_d;
        int_q        <= int_d;
        frac_q       <= frac_d;
        phase_q      <= phase_d;
      end
    end
  end

endmodule

// ===== hdl/fdfp_queue.sv =====
module fdfp_queue #(
  parameter int unsigned Depth = fdfp_pkg::SUM_QUEUE_DEPTH
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  fdfp_pkg::frame_sum_t data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output fdfp_pkg::frame_sum_t data_o
);
  import fdfp_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  frame_sum_t      mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

// ===== hdl/fdfp_back.sv =====
module fdfp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [fdfp_pkg::ByteW-1:0] max_line_i,
  input  logic [fdfp_pkg::ByteW-1:0] max_screen_i,
  input  logic                       sum_valid_i,
  input  fdfp_pkg::frame_sum_t       sum_i,
  output logic                       sum_pop_o,
  output logic                       res_valid_o,
  input  logic                       res_pop_i,
  output fdfp_pkg::result_t          res_o
);
  import fdfp_pkg::*;

  result_t          res_d, res_q;
  logic             valid_q;
  logic [ByteW-1:0] d0_digit, d1_row, d0_row;
  logic             one_param;

  assign d0_digit  = sum_i.d0 - ASCII_ZERO;
  assign d1_row    = sum_i.d1 - ASCII_ONE;
  assign d0_row    = sum_i.d0 - ASCII_ONE;
  assign one_param = (sum_i.dl == 8'd1);

  always_comb begin
    res_d = '0;
    res_d.status = ST_OK;
    if (sum_i.frame_bad) begin
      res_d.status = ST_FRAME_ERR;
    end else if (sum_i.cmd == CMD_NONE) begin
      res_d.status = ST_CMD_ERR;
    end else if (sum_i.len_short) begin
      res_d.status  = ST_FRAME_ERR;
      res_d.command = sum_i.cmd;
    end else begin
      res_d.command   = sum_i.cmd;
      res_d.param_len = sum_i.dl;
      case (sum_i.cmd)
        CMD_1, CMD_2, CMD_5: begin
          if (sum_i.dl != 8'd0) res_d.status = ST_PARAM_ERR;
        end
        CMD_LINE: begin
          if (sum_i.dl < 8'd3 || sum_i.dl > max_line_i) begin
            res_d.status = ST_PARAM_ERR;
          end else begin
            res_d.colour     = d0_digit;
            res_d.row        = d1_row;
            res_d.text_bytes = sum_i.dl - 8'd2;
            if (d0_digit > 8'd2 || d1_row > 8'd4) res_d.status = ST_PARAM_ERR;
          end
        end
        CMD_SCREEN: begin
          if (sum_i.dl < 8'd4 || sum_i.dl > max_screen_i) begin
            res_d.status = ST_PARAM_ERR;
          end else begin
            res_d.colour     = d0_digit;
            res_d.x_pos      = sum_i.d1;
            res_d.y_pos      = sum_i.d2;
            res_d.text_bytes = sum_i.dl - 8'd3;
            if (d0_digit > 8'd2) res_d.status = ST_PARAM_ERR;
          end
        end
        CMD_ROW_CLR: begin
          if (!one_param) begin
            res_d.status = ST_PARAM_ERR;
          end else begin
            res_d.row = d0_row;
            if (d0_row > 8'd4) res_d.status = ST_PARAM_ERR;
          end
        end
        CMD_VOICE: begin
          if (!one_param) begin
            res_d.status = ST_PARAM_ERR;
          end else begin
            res_d.level_value = d0_digit;
            if (d0_digit > 8'd3) res_d.status = ST_PARAM_ERR;
          end
        end
        CMD_BRIGHT: begin
          if (!one_param) begin
            res_d.status = ST_PARAM_ERR;
          end else if (sum_i.d0 == 8'd0) begin
            res_d.level_value = 8'd0;
          end else if (sum_i.d0 >= ASCII_ONE && sum_i.d0 <= 8'h38) begin
            res_d.level_value = d0_digit;
          end else begin
            res_d.status = ST_PARAM_ERR;
          end
        end
        CMD_VOLUME: begin
          if (!one_param) begin
            res_d.status = ST_PARAM_ERR;
          end else begin
            res_d.level_value = d0_digit;
            if (d0_digit < 8'd1 || d0_digit > 8'd5) res_d.status = ST_PARAM_ERR;
          end
        end
        CMD_PERIPH: begin
          if (!one_param) begin
            res_d.status = ST_PARAM_ERR;
          end else begin
            res_d.level_value = sum_i.d0;
          end
        end
        CMD_FEE: begin
          if (sum_i.dl == 8'd0) begin
            res_d.status = ST_PARAM_ERR;
          end else begin
            res_d.fee_amount = sum_i.int_accum * 32'd100 + {25'd0, sum_i.frac};
          end
        end
        CMD_FILL: begin
          if (!one_param || sum_i.d0 < 8'd1 || sum_i.d0 > 8'd7) begin
            res_d.status = ST_PARAM_ERR;
          end else begin
            res_d.colour = sum_i.d0;
          end
        end
        CMD_VERSION: begin
          if (!one_param) res_d.status = ST_PARAM_ERR;
        end
        default: begin
          res_d.status = ST_OK;
        end
      endcase
    end
  end

  // A waiting summary refills the output register when empty or drained.
  assign sum_pop_o   = sum_valid_i && (!valid_q || res_pop_i);
  assign res_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i) begin
    if (sum_pop_o) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sum_pop_o) begin
      valid_q <= 1'b1;
    end else if (res_pop_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

// ===== hdl/fee_display_frame_parser_top.sv =====
// Channel   Direction  Signals                                Transfer when
// input     in         push, full, frame_byte_i, last_byte_i  push & !full
// result    out        empty, pop, status_o .. fee_amount_o   pop & !empty
// config    in         cfg_we_i, cfg_idx_i, cfg_wdata_i       cfg_we_i
//
// One byte is taken in each cycle that push is high and full is low. The summary
// queue is written at the transfer of a frame's last byte; the back end loads
// its result register from the queue once that register is empty or popped.
// Reset clears all frame state and loads the length limits with 18 and 86.
// full rises only while the summary queue holds QueueDepth frames that the back
// end has not taken; the back end stalls while its result is not popped.
module fee_display_frame_parser_top #(
  parameter int unsigned QueueDepth = fdfp_pkg::SUM_QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [fdfp_pkg::ByteW-1:0]    frame_byte_i,
  input  logic                          last_byte_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status_o,
  output logic [fdfp_pkg::CmdW-1:0]     command_o,
  output logic [fdfp_pkg::ByteW-1:0]    param_len_o,
  output logic [fdfp_pkg::ByteW-1:0]    colour_o,
  output logic [fdfp_pkg::ByteW-1:0]    row_o,
  output logic [fdfp_pkg::ByteW-1:0]    x_pos_o,
  output logic [fdfp_pkg::ByteW-1:0]    y_pos_o,
  output logic [fdfp_pkg::ByteW-1:0]    text_bytes_o,
  output logic [fdfp_pkg::ByteW-1:0]    level_value_o,
  output logic [fdfp_pkg::AmountW-1:0]  fee_amount_o,
  input  logic                          cfg_we_i,
  input  logic [fdfp_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [fdfp_pkg::ByteW-1:0]    cfg_wdata_i
);
  import fdfp_pkg::*;

  logic [ByteW-1:0] max_line_q, max_screen_q;
  logic             in_accept;
  logic             sum_push, sum_pop, sum_empty;
  frame_sum_t       sum_in, sum_out;
  logic             res_valid;
  result_t          res;

  // Length limits for the text commands.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_line_q   <= MAX_LINE_RESET;
      max_screen_q <= MAX_SCREEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_LINE:   max_line_q   <= cfg_wdata_i;
        REG_MAX_SCREEN: max_screen_q <= cfg_wdata_i;
        default:        max_line_q   <= max_line_q;
      endcase
    end
  end

  assign in_accept = push && !full;

  // The front end tracks the frame byte by byte and hands a summary of each
  // finished frame to the queue on its last byte.
  fdfp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_accept),
    .frame_byte_i (frame_byte_i),
    .last_byte_i  (last_byte_i),
    .sum_push_o   (sum_push),
    .sum_o        (sum_in)
  );

  fdfp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (sum_push),
    .data_i  (sum_in),
    .full_o  (full),
    .pop_i   (sum_pop),
    .empty_o (sum_empty),
    .data_o  (sum_out)
  );

  // The back end runs the per-command checks and holds the result register.
  fdfp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_line_i   (max_line_q),
    .max_screen_i (max_screen_q),
    .sum_valid_i  (!sum_empty),
    .sum_i        (sum_out),
    .sum_pop_o    (sum_pop),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .res_o        (res)
  );

  assign empty         = !res_valid;
  assign status_o      = res.status;
  assign command_o     = res.command;
  assign param_len_o   = res.param_len;
  assign colour_o      = res.colour;
  assign row_o         = res.row;
  assign x_pos_o       = res.x_pos;
  assign y_pos_o       = res.y_pos;
  assign text_bytes_o  = res.text_bytes;
  assign level_value_o = res.level_value;
  assign fee_amount_o  = res.fee_amount;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the fee display frame parser. Frames are fed byte by
// byte through the push/full side. A predictor built into the bench follows
// every transfer it sees on that side and queues the result expected for each
// byte flagged last. Results are taken from the empty/pop side and compared
// field by field, oldest first. The length limits are rewritten between test
// phases, but only while nothing is outstanding. Each phase sets its own mix
// of sender gaps and receiver stalls; the first two phases use neither.
module testbench;
  import fdfp_pkg::*;

  // Command bytes that have no digit form, and the ASCII digit eight.
  localparam logic [ByteW-1:0] CODE_PERIPH  = 8'h41;
  localparam logic [ByteW-1:0] CODE_FEE     = 8'h42;
  localparam logic [ByteW-1:0] CODE_FILL    = 8'h01;
  localparam logic [ByteW-1:0] CODE_VERSION = 8'h02;
  localparam logic [ByteW-1:0] ASCII_EIGHT  = 8'h38;

  typedef enum logic [1:0] {AMT_INT, AMT_DOT, AMT_FRAC2, AMT_DONE} amt_phase_e;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                push = 1'b0;
  logic                full;
  logic [ByteW-1:0]    frame_byte_i = '0;
  logic                last_byte_i = 1'b0;
  logic                empty;
  logic                pop = 1'b0;
  logic [1:0]          status_o;
  logic [CmdW-1:0]     command_o;
  logic [ByteW-1:0]    param_len_o;
  logic [ByteW-1:0]    colour_o;
  logic [ByteW-1:0]    row_o;
  logic [ByteW-1:0]    x_pos_o;
  logic [ByteW-1:0]    y_pos_o;
  logic [ByteW-1:0]    text_bytes_o;
  logic [ByteW-1:0]    level_value_o;
  logic [AmountW-1:0]  fee_amount_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [ByteW-1:0]    cfg_wdata_i = '0;

  // Predictor copy of the limit registers and of the per-frame state.
  logic [ByteW-1:0]    lim_line;
  logic [ByteW-1:0]    lim_screen;
  logic [CountW-1:0]   fr_count;
  logic                fr_open;
  logic [CmdW-1:0]     fr_cmd;
  logic [ByteW-1:0]    fr_len;
  logic [ByteW-1:0]    fr_head [3];
  logic [AmountW-1:0]  fr_int;
  logic [FracW-1:0]    fr_frac;
  amt_phase_e          fr_phase;

  result_t             pending_results [$];
  logic [ByteW-1:0]    frame_q [$];
  int unsigned         err_count = 0;
  int unsigned         bytes_sent = 0;
  int unsigned         send_idle_pct = 0;
  int unsigned         stall_pct = 0;

  fee_display_frame_parser_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .frame_byte_i  (frame_byte_i),
    .last_byte_i   (last_byte_i),
    .empty         (empty),
    .pop           (pop),
    .status_o      (status_o),
    .command_o     (command_o),
    .param_len_o   (param_len_o),
    .colour_o      (colour_o),
    .row_o         (row_o),
    .x_pos_o       (x_pos_o),
    .y_pos_o       (y_pos_o),
    .text_bytes_o  (text_bytes_o),
    .level_value_o (level_value_o),
    .fee_amount_o  (fee_amount_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Frame decode predictor
  // ---------------------------------------------------------------------------

  function automatic logic [CmdW-1:0] cmd_of_byte(input logic [ByteW-1:0] b);
    if (b >= ASCII_ONE && b <= ASCII_NINE) return CmdW'(b - ASCII_ZERO);
    case (b)
      CODE_PERIPH:  return CMD_PERIPH;
      CODE_FEE:     return CMD_FEE;
      CODE_FILL:    return CMD_FILL;
      CODE_VERSION: return CMD_VERSION;
      default:      return CMD_NONE;
    endcase
  endfunction

  function automatic void clear_frame();
    fr_count = '0;
    fr_open  = 1'b0;
    fr_cmd   = CMD_NONE;
    fr_len   = '0;
    for (int i = 0; i < 3; i++) fr_head[i] = '0;
    fr_int   = '0;
    fr_frac  = '0;
    fr_phase = AMT_INT;
  endfunction

  // ASCII decimal amount: integer digits, an optional dot, at most two
  // fraction digits. Anything unexpected closes the amount.
  function automatic void accumulate_amount(input logic [ByteW-1:0] b);
    logic               is_digit;
    logic [AmountW-1:0] d;
    is_digit = (b >= ASCII_ZERO && b <= ASCII_NINE);
    d = AmountW'(b) - AmountW'(ASCII_ZERO);
    case (fr_phase)
      AMT_INT: begin
        if (is_digit) fr_int = fr_int * 10 + d;
        else fr_phase = (b == ASCII_DOT) ? AMT_DOT : AMT_DONE;
      end
      AMT_DOT: begin
        if (is_digit) begin
          fr_frac  = FracW'(d * 10);
          fr_phase = AMT_FRAC2;
        end else begin
          fr_phase = AMT_DONE;
        end
      end
      AMT_FRAC2: begin
        if (is_digit) fr_frac = FracW'(fr_frac + d);
        fr_phase = AMT_DONE;
      end
      default: fr_phase = AMT_DONE;
    endcase
  endfunction

  // Advances the frame state by one byte; returns 1 with the decoded result
  // when the byte closes the frame.
  function automatic bit decode_frame_byte(input logic [ByteW-1:0] b, input logic last,
                                           output result_t res);
    logic [CountW-1:0] idx;
    logic [31:0]       pos;
    logic [31:0]       total;
    logic [ByteW-1:0]  dl;
    logic [ByteW-1:0]  d0;
    logic [ByteW-1:0]  d1;
    logic [ByteW-1:0]  d2;
    res = '0;
    idx = fr_count;
    if (idx == 0) begin
      fr_open = (b == OPEN_MARK);
    end else if (idx == 1) begin
      fr_cmd = cmd_of_byte(b);
    end else if (idx == 2) begin
      fr_len = b;
    end else begin
      pos = 32'(idx) - 3;
      if (pos < 32'(fr_len)) begin
        if (pos < 3) fr_head[pos[1:0]] = b;
        accumulate_amount(b);
      end
    end
    if (fr_count != '1) fr_count = fr_count + CountW'(1);
    if (!last) return 1'b0;

    total = 32'(idx) + 1;
    dl = fr_len;
    d0 = fr_head[0];
    d1 = fr_head[1];
    d2 = fr_head[2];
    if (total < 4 || !fr_open || b != CLOSE_MARK) begin
      res.status = ST_FRAME_ERR;
    end else if (fr_cmd == CMD_NONE) begin
      res.status = ST_CMD_ERR;
    end else if (total - 4 < 32'(dl)) begin
      // Too few bytes for the declared length: the command survives.
      res.status  = ST_FRAME_ERR;
      res.command = fr_cmd;
    end else begin
      res.command   = fr_cmd;
      res.param_len = dl;
      case (fr_cmd)
        CMD_1, CMD_2, CMD_5: begin
          if (dl != 0) res.status = ST_PARAM_ERR;
        end
        CMD_LINE: begin
          if (dl < 3 || dl > lim_line) begin
            res.status = ST_PARAM_ERR;
          end else begin
            res.colour     = d0 - ASCII_ZERO;
            res.row        = d1 - ASCII_ONE;
            res.text_bytes = dl - 8'd2;
            if (res.colour > 2 || res.row > 4) res.status = ST_PARAM_ERR;
          end
        end
        CMD_SCREEN: begin
          if (dl < 4 || dl > lim_screen) begin
            res.status = ST_PARAM_ERR;
          end else begin
            res.colour     = d0 - ASCII_ZERO;
            res.x_pos      = d1;
            res.y_pos      = d2;
            res.text_bytes = dl - 8'd3;
            if (res.colour > 2) res.status = ST_PARAM_ERR;
          end
        end
        CMD_ROW_CLR: begin
          if (dl != 1) begin
            res.status = ST_PARAM_ERR;
          end else begin
            res.row = d0 - ASCII_ONE;
            if (res.row > 4) res.status = ST_PARAM_ERR;
          end
        end
        CMD_VOICE: begin
          if (dl != 1) begin
            res.status = ST_PARAM_ERR;
          end else begin
            res.level_value = d0 - ASCII_ZERO;
            if (res.level_value > 3) res.status = ST_PARAM_ERR;
          end
        end
        CMD_BRIGHT: begin
          if (dl != 1) res.status = ST_PARAM_ERR;
          else if (d0 == 0) res.level_value = '0;
          else if (d0 >= ASCII_ONE && d0 <= ASCII_EIGHT) res.level_value = d0 - ASCII_ZERO;
          else res.status = ST_PARAM_ERR;
        end
        CMD_VOLUME: begin
          if (dl != 1) begin
            res.status = ST_PARAM_ERR;
          end else begin
            res.level_value = d0 - ASCII_ZERO;
            if (res.level_value < 1 || res.level_value > 5) res.status = ST_PARAM_ERR;
          end
        end
        CMD_PERIPH: begin
          if (dl != 1) res.status = ST_PARAM_ERR;
          else res.level_value = d0;
        end
        CMD_FEE: begin
          if (dl < 1) res.status = ST_PARAM_ERR;
          else res.fee_amount = fr_int * 100 + AmountW'(fr_frac);
        end
        CMD_FILL: begin
          if (dl != 1 || d0 < 1 || d0 > 7) res.status = ST_PARAM_ERR;
          else res.colour = d0;
        end
        CMD_VERSION: begin
          if (dl != 1) res.status = ST_PARAM_ERR;
        end
        default: ;
      endcase
    end
    clear_frame();
    return 1'b1;
  endfunction

  // Follows register writes and every byte transfer on the input side.
  always @(posedge clk_i) begin : track_input
    result_t res;
    if (!rst_ni) begin
      lim_line   = MAX_LINE_RESET;
      lim_screen = MAX_SCREEN_RESET;
      clear_frame();
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_MAX_LINE) lim_line = cfg_wdata_i;
        else if (cfg_idx_i == REG_MAX_SCREEN) lim_screen = cfg_wdata_i;
      end
      if (push && !full) begin
        if (decode_frame_byte(frame_byte_i, last_byte_i, res)) pending_results.push_back(res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: random stalls and the field-by-field comparison
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) pop <= ($urandom_range(99) >= stall_pct);

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch: expected 0x%0h, got 0x%0h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result transfer with nothing expected (status %0d, command %0d)",
                 $time, status_o, command_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status",      32'(want.status),      32'(status_o));
        compare_field("command",     32'(want.command),     32'(command_o));
        compare_field("param_len",   32'(want.param_len),   32'(param_len_o));
        compare_field("colour",      32'(want.colour),      32'(colour_o));
        compare_field("row",         32'(want.row),         32'(row_o));
        compare_field("x_pos",       32'(want.x_pos),       32'(x_pos_o));
        compare_field("y_pos",       32'(want.y_pos),       32'(y_pos_o));
        compare_field("text_bytes",  32'(want.text_bytes),  32'(text_bytes_o));
        compare_field("level_value", 32'(want.level_value), 32'(level_value_o));
        compare_field("fee_amount",  want.fee_amount,       fee_amount_o);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Sends one byte: drives push with it, then waits at clock edges until full is low.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    frame_byte_i <= b;
    last_byte_i  <= last;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Holds the sender until every queued result has been taken, then lets
  // the back end settle.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic set_limits(input logic [ByteW-1:0] line_max, input logic [ByteW-1:0] screen_max);
    drain();
    write_reg(REG_MAX_LINE, line_max);
    write_reg(REG_MAX_SCREEN, screen_max);
  endtask

  function automatic logic [ByteW-1:0] pick_cmd_byte();
    int unsigned k;
    k = $urandom_range(12);
    if (k < 9) return ASCII_ONE + ByteW'(k);
    case (k)
      9:       return CODE_PERIPH;
      10:      return CODE_FEE;
      11:      return CODE_FILL;
      default: return CODE_VERSION;
    endcase
  endfunction

  // Mostly lengths the command accepts, with the limits and their
  // neighbours hit now and then.
  function automatic logic [ByteW-1:0] pick_len(input logic [CmdW-1:0] cmd);
    int unsigned r;
    r = $urandom_range(9);
    case (cmd)
      CMD_1, CMD_2, CMD_5: return (r < 7) ? 8'd0 : ByteW'($urandom_range(1, 3));
      CMD_LINE: begin
        if (r == 0) return ByteW'($urandom_range(0, 2));
        if (r == 1) return lim_line;
        if (r == 2) return lim_line + 8'd1;
        return ByteW'($urandom_range(3, (lim_line < 20) ? lim_line : 20));
      end
      CMD_SCREEN: begin
        if (r == 0) return ByteW'($urandom_range(0, 3));
        if (r == 1) return lim_screen;
        if (r == 2) return lim_screen + 8'd1;
        return ByteW'($urandom_range(4, (lim_screen < 30) ? lim_screen : 30));
      end
      CMD_FEE: return (r == 0) ? 8'd0 : ByteW'($urandom_range(1, 14));
      default: return (r == 0) ? 8'd0 : (r == 1) ? 8'd2 : 8'd1;
    endcase
  endfunction

  function automatic logic [ByteW-1:0] pick_param(input logic [CmdW-1:0] cmd, input int unsigned i);
    int unsigned r;
    if ($urandom_range(11) == 0) return ByteW'($urandom);
    case (cmd)
      CMD_LINE: begin
        if (i == 0) return ASCII_ZERO + ByteW'($urandom_range(0, 3));
        if (i == 1) return ASCII_ZERO + ByteW'($urandom_range(0, 6));
        return ByteW'($urandom);
      end
      CMD_SCREEN:  return (i == 0) ? ASCII_ZERO + ByteW'($urandom_range(0, 3)) : ByteW'($urandom);
      CMD_ROW_CLR: return ASCII_ZERO + ByteW'($urandom_range(0, 6));
      CMD_VOICE:   return ASCII_ZERO + ByteW'($urandom_range(0, 5));
      CMD_VOLUME:  return ASCII_ZERO + ByteW'($urandom_range(0, 6));
      CMD_BRIGHT: begin
        r = $urandom_range(10);
        return (r == 0) ? 8'd0 : ASCII_ZERO + ByteW'(r - 1);
      end
      CMD_FILL:    return ByteW'($urandom_range(0, 8));
      default:     return ByteW'($urandom);
    endcase
  endfunction

  // One random frame. Most are well formed; a few are noise, truncated,
  // or carry a wrong opening or closing byte.
  task automatic send_random_frame();
    logic [ByteW-1:0] cmd_b;
    logic [ByteW-1:0] plen;
    logic [ByteW-1:0] amt [$];
    logic [CmdW-1:0]  cmd;
    int unsigned      kind;
    int unsigned      flaw;
    int unsigned      keep;
    frame_q.delete();
    kind = $urandom_range(99);
    if (kind < 5) begin
      repeat ($urandom_range(1, 3)) frame_q.push_back(ByteW'($urandom));
      send_frame();
      return;
    end
    cmd_b = (kind < 10) ? ByteW'($urandom) : pick_cmd_byte();
    cmd   = cmd_of_byte(cmd_b);
    plen  = pick_len(cmd);
    frame_q.push_back(OPEN_MARK);
    frame_q.push_back(cmd_b);
    frame_q.push_back(plen);
    if (cmd == CMD_FEE && $urandom_range(7) != 0) begin
      // Integer digits (sometimes enough to wrap), an optional dot and
      // up to three fraction digits, then filler.
      repeat ($urandom_range(0, 12)) amt.push_back(ASCII_ZERO + ByteW'($urandom_range(0, 9)));
      if ($urandom_range(3) != 0) begin
        amt.push_back(ASCII_DOT);
        repeat ($urandom_range(0, 3)) amt.push_back(ASCII_ZERO + ByteW'($urandom_range(0, 9)));
      end
      for (int i = 0; i < plen; i++) frame_q.push_back((i < amt.size()) ? amt[i] : ByteW'($urandom));
    end else begin
      for (int i = 0; i < plen; i++) frame_q.push_back(pick_param(cmd, i));
    end
    if ($urandom_range(4) == 0) begin
      repeat ($urandom_range(1, 3)) frame_q.push_back(ByteW'($urandom));
    end
    flaw = $urandom_range(19);
    if (flaw == 0 && frame_q.size() > 3) begin
      keep = $urandom_range(2, frame_q.size() - 1);
      while (frame_q.size() > keep) frame_q.delete(frame_q.size() - 1);
    end else if (flaw == 1) begin
      frame_q[0] = ByteW'($urandom);
    end
    frame_q.push_back((flaw == 2) ? ByteW'($urandom) : CLOSE_MARK);
    send_frame();
  endtask

  task automatic run_random_frames(input int unsigned n_bytes);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) send_random_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Framing errors, an unknown command, a frame too short for its length,
  // a fractional fee and the largest fill colour.
  task automatic test_directed();
    send_idle_pct = 0;
    stall_pct     = 0;
    frame_q = '{OPEN_MARK, CLOSE_MARK};
    send_frame();
    frame_q = '{8'hFF};
    send_frame();
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{OPEN_MARK, 8'h00, 8'h00, CLOSE_MARK};
    send_frame();
    frame_q = '{OPEN_MARK, ASCII_ONE, 8'hFF, CLOSE_MARK};
    send_frame();
    frame_q = '{OPEN_MARK, CODE_FEE, 8'd3, ASCII_ONE, ASCII_DOT, ASCII_ZERO + 8'd5, CLOSE_MARK};
    send_frame();
    frame_q = '{OPEN_MARK, CODE_FILL, 8'd1, 8'd7, CLOSE_MARK};
    send_frame();
  endtask

  task automatic test_reset_limits();
    set_limits(MAX_LINE_RESET, MAX_SCREEN_RESET);
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_frames(80);
  endtask

  task automatic test_min_limits();
    set_limits(8'd3, 8'd4);
    send_idle_pct = 65;
    stall_pct     = 0;
    run_random_frames(80);
  endtask

  task automatic test_max_limits();
    set_limits(8'd255, 8'd255);
    send_idle_pct = 0;
    stall_pct     = 65;
    run_random_frames(80);
  endtask

  // Limits below their intended floor apply as written; then arbitrary ones.
  task automatic test_odd_limits();
    set_limits(ByteW'($urandom_range(0, 2)), ByteW'($urandom_range(0, 3)));
    send_idle_pct = 13;
    stall_pct     = 13;
    run_random_frames(40);
    set_limits(ByteW'($urandom_range(3, 255)), ByteW'($urandom_range(4, 255)));
    run_random_frames(40);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reset_limits();
    test_min_limits();
    test_max_limits();
    test_odd_limits();
    drain();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog: the slowest legal run stays far below this.
  initial begin
    #(20_000_000);
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
